// ===== rtl/bary3d_pkg.sv =====
// shared constants for the 3d barycentric weight pipeline
package bary3d_pkg;

  localparam int COORD_WIDTH_DEF      = 16;
  localparam int WEIGHT_FRAC_BITS_DEF = 16;
  localparam int WEIGHT_W             = 20;
  localparam int TAG_W                = 3;

  // sideband tag bit positions carried through the divider
  localparam int TAG_NEG_U = 0;
  localparam int TAG_NEG_V = 1;
  localparam int TAG_DEG   = 2;

endpackage

// ===== rtl/bary3d_div.sv =====
// pipelined restoring divider, one quotient bit per stage, two numerators over one divisor
module bary3d_div #(
  parameter int NUM_W = 53,
  parameter int DEN_W = 36
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [NUM_W-1:0]               in_num_u,
  input  logic [NUM_W-1:0]               in_num_v,
  input  logic [DEN_W-1:0]               in_den,
  input  logic [bary3d_pkg::TAG_W-1:0]   in_tag,
  output logic                           out_valid,
  output logic [NUM_W-1:0]               out_quo_u,
  output logic [NUM_W-1:0]               out_quo_v,
  output logic [bary3d_pkg::TAG_W-1:0]   out_tag
);

  localparam int RW = DEN_W + 1;

  logic                         valid_r [NUM_W];
  logic [NUM_W-1:0]             nu_r    [NUM_W];
  logic [NUM_W-1:0]             nv_r    [NUM_W];
  logic [NUM_W-1:0]             qu_r    [NUM_W];
  logic [NUM_W-1:0]             qv_r    [NUM_W];
  logic [RW-1:0]                ru_r    [NUM_W];
  logic [RW-1:0]                rv_r    [NUM_W];
  logic [DEN_W-1:0]             den_r   [NUM_W];
  logic [bary3d_pkg::TAG_W-1:0] tag_r   [NUM_W];

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic                         pv;
    logic [NUM_W-1:0]             pnu, pnv, pqu, pqv;
    logic [RW-1:0]                pru, prv;
    logic [DEN_W-1:0]             pden;
    logic [bary3d_pkg::TAG_W-1:0] ptag;
    logic [RW-1:0]                shu, shv;
    logic                         geu, gev;

    if (s == 0) begin : g_first
      assign pv   = in_valid;
      assign pnu  = in_num_u;
      assign pnv  = in_num_v;
      assign pqu  = '0;
      assign pqv  = '0;
      assign pru  = '0;
      assign prv  = '0;
      assign pden = in_den;
      assign ptag = in_tag;
    end else begin : g_next
      assign pv   = valid_r[s-1];
      assign pnu  = nu_r[s-1];
      assign pnv  = nv_r[s-1];
      assign pqu  = qu_r[s-1];
      assign pqv  = qv_r[s-1];
      assign pru  = ru_r[s-1];
      assign prv  = rv_r[s-1];
      assign pden = den_r[s-1];
      assign ptag = tag_r[s-1];
    end

    // bring down the next numerator bit, then trial subtract
    assign shu = {pru[RW-2:0], pnu[NUM_W-1]};
    assign shv = {prv[RW-2:0], pnv[NUM_W-1]};
    assign geu = (shu >= {1'b0, pden});
    assign gev = (shv >= {1'b0, pden});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[s] <= 1'b0;
      end else if (en) begin
        valid_r[s] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nu_r[s]  <= {pnu[NUM_W-2:0], 1'b0};
        nv_r[s]  <= {pnv[NUM_W-2:0], 1'b0};
        qu_r[s]  <= {pqu[NUM_W-2:0], geu};
        qv_r[s]  <= {pqv[NUM_W-2:0], gev};
        ru_r[s]  <= geu ? (shu - {1'b0, pden}) : shu;
        rv_r[s]  <= gev ? (shv - {1'b0, pden}) : shv;
        den_r[s] <= pden;
        tag_r[s] <= ptag;
      end
    end
  end

  assign out_valid = valid_r[NUM_W-1];
  assign out_quo_u = qu_r[NUM_W-1];
  assign out_quo_v = qv_r[NUM_W-1];
  assign out_tag   = tag_r[NUM_W-1];

endmodule

// ===== rtl/barycentric_triangle_3d_core.sv =====
// Barycentric weights of a query point against a 3d triangle. One request can enter every
// clock cycle while out_stall does not hold the pipeline; the one-bit-per-stage divider
// follows five stages of edge differences, normal products, axis choice, area products
// and magnitude forming. out_stall freezes the whole pipeline and shows up at in_stall in
// the same cycle only while a result is held at the output. Weights are signed with
// WEIGHT_FRAC_BITS fraction bits, rounded to nearest with ties away from zero and
// saturated to 20 bits; a zero projected normal gives zero weights and raises degenerate.
module barycentric_triangle_3d_core #(
  parameter int COORD_WIDTH      = bary3d_pkg::COORD_WIDTH_DEF,
  parameter int WEIGHT_FRAC_BITS = bary3d_pkg::WEIGHT_FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [COORD_WIDTH-1:0]          in_a_x,
  input  logic signed [COORD_WIDTH-1:0]          in_a_y,
  input  logic signed [COORD_WIDTH-1:0]          in_a_z,
  input  logic signed [COORD_WIDTH-1:0]          in_b_x,
  input  logic signed [COORD_WIDTH-1:0]          in_b_y,
  input  logic signed [COORD_WIDTH-1:0]          in_b_z,
  input  logic signed [COORD_WIDTH-1:0]          in_c_x,
  input  logic signed [COORD_WIDTH-1:0]          in_c_y,
  input  logic signed [COORD_WIDTH-1:0]          in_c_z,
  input  logic signed [COORD_WIDTH-1:0]          in_q_x,
  input  logic signed [COORD_WIDTH-1:0]          in_q_y,
  input  logic signed [COORD_WIDTH-1:0]          in_q_z,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [bary3d_pkg::WEIGHT_W-1:0] out_weight_a,
  output logic signed [bary3d_pkg::WEIGHT_W-1:0] out_weight_b,
  output logic signed [bary3d_pkg::WEIGHT_W-1:0] out_weight_c,
  output logic                                   out_degenerate
);

  localparam int DW    = COORD_WIDTH + 1;
  localparam int PW    = 2 * DW;
  localparam int MW    = PW + 1;
  localparam int NUM_W = MW + WEIGHT_FRAC_BITS + 2;
  localparam int DEN_W = MW + 1;
  localparam int SW    = NUM_W + 3;
  localparam int OW    = bary3d_pkg::WEIGHT_W;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  localparam logic signed [SW-1:0] W_ONE = SW'(1) <<< WEIGHT_FRAC_BITS;
  localparam logic signed [SW-1:0] W_MAX = (SW'(1) <<< (OW - 1)) - SW'(1);
  localparam logic signed [SW-1:0] W_MIN = -(SW'(1) <<< (OW - 1));

  logic en;
  logic out_valid_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // stage 1: coordinate differences
  logic signed [DW-1:0] pa [3], pb [3], pc [3], pq [3];

  assign pa[0] = {in_a_x[COORD_WIDTH-1], in_a_x};
  assign pa[1] = {in_a_y[COORD_WIDTH-1], in_a_y};
  assign pa[2] = {in_a_z[COORD_WIDTH-1], in_a_z};
  assign pb[0] = {in_b_x[COORD_WIDTH-1], in_b_x};
  assign pb[1] = {in_b_y[COORD_WIDTH-1], in_b_y};
  assign pb[2] = {in_b_z[COORD_WIDTH-1], in_b_z};
  assign pc[0] = {in_c_x[COORD_WIDTH-1], in_c_x};
  assign pc[1] = {in_c_y[COORD_WIDTH-1], in_c_y};
  assign pc[2] = {in_c_z[COORD_WIDTH-1], in_c_z};
  assign pq[0] = {in_q_x[COORD_WIDTH-1], in_q_x};
  assign pq[1] = {in_q_y[COORD_WIDTH-1], in_q_y};
  assign pq[2] = {in_q_z[COORD_WIDTH-1], in_q_z};

  logic                 v1_r;
  logic signed [DW-1:0] e1_r [3], e2_r [3], qb1_r [3], bc1_r [3], qc1_r [3], ca1_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        e1_r[k]  <= pb[k] - pa[k];
        e2_r[k]  <= pc[k] - pa[k];
        qb1_r[k] <= pq[k] - pb[k];
        bc1_r[k] <= pb[k] - pc[k];
        qc1_r[k] <= pq[k] - pc[k];
        ca1_r[k] <= pc[k] - pa[k];
      end
    end
  end

  // stage 2: cross product terms
  logic                 v2_r;
  logic signed [PW-1:0] pm_r [6];
  logic signed [DW-1:0] qb2_r [3], bc2_r [3], qc2_r [3], ca2_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      pm_r[0] <= e1_r[1] * e2_r[2];
      pm_r[1] <= e1_r[2] * e2_r[1];
      pm_r[2] <= e1_r[2] * e2_r[0];
      pm_r[3] <= e1_r[0] * e2_r[2];
      pm_r[4] <= e1_r[0] * e2_r[1];
      pm_r[5] <= e1_r[1] * e2_r[0];
      qb2_r   <= qb1_r;
      bc2_r   <= bc1_r;
      qc2_r   <= qc1_r;
      ca2_r   <= ca1_r;
    end
  end

  // stage 3: normal, dominant axis and projected operands
  logic signed [MW-1:0] m [3];
  logic        [MW-1:0] am [3];
  logic [1:0]           axis;
  logic signed [MW-1:0] d_sel;
  logic [1:0]           i1, i2;

  always_comb begin
    m[0] = MW'(pm_r[0]) - MW'(pm_r[1]);
    m[1] = MW'(pm_r[2]) - MW'(pm_r[3]);
    m[2] = MW'(pm_r[4]) - MW'(pm_r[5]);
    for (int k = 0; k < 3; k++) begin
      am[k] = m[k][MW-1] ? -m[k] : m[k];
    end
    // ties go to x, then y
    if (am[0] >= am[1] && am[0] >= am[2]) begin
      axis = AX_X;
    end else if (am[1] >= am[2]) begin
      axis = AX_Y;
    end else begin
      axis = AX_Z;
    end
    case (axis)
      AX_X: begin
        i1 = 2'd1; i2 = 2'd2; d_sel = m[0];
      end
      AX_Y: begin
        i1 = 2'd0; i2 = 2'd2; d_sel = -m[1];
      end
      AX_Z: begin
        i1 = 2'd0; i2 = 2'd1; d_sel = m[2];
      end
      default: begin
        i1 = 2'd0; i2 = 2'd1; d_sel = m[2];
      end
    endcase
  end

  logic                 v3_r;
  logic signed [MW-1:0] d3_r;
  logic signed [DW-1:0] qb_a_r, bc_b_r, bc_a_r, qb_b_r;
  logic signed [DW-1:0] qc_a_r, ca_b_r, ca_a_r, qc_b_r;

  always_ff @(posedge clk) begin
    if (en) begin
      d3_r   <= d_sel;
      qb_a_r <= qb2_r[i1];
      bc_b_r <= bc2_r[i2];
      bc_a_r <= bc2_r[i1];
      qb_b_r <= qb2_r[i2];
      qc_a_r <= qc2_r[i1];
      ca_b_r <= ca2_r[i2];
      ca_a_r <= ca2_r[i1];
      qc_b_r <= qc2_r[i2];
    end
  end

  // stage 4: area products
  logic                 v4_r;
  logic signed [MW-1:0] d4_r;
  logic signed [PW-1:0] pu0_r, pu1_r, pv0_r, pv1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      d4_r  <= d3_r;
      pu0_r <= qb_a_r * bc_b_r;
      pu1_r <= bc_a_r * qb_b_r;
      pv0_r <= qc_a_r * ca_b_r;
      pv1_r <= ca_a_r * qc_b_r;
    end
  end

  // stage 5: areas to magnitudes, rounding offset folded into the numerator
  logic signed [MW-1:0] nu, nv;
  logic        [MW-1:0] anu, anv, ad;

  assign nu  = MW'(pu0_r) - MW'(pu1_r);
  assign nv  = MW'(pv0_r) - MW'(pv1_r);
  assign anu = nu[MW-1] ? -nu : nu;
  assign anv = nv[MW-1] ? -nv : nv;
  assign ad  = d4_r[MW-1] ? -d4_r : d4_r;

  logic                         v5_r;
  logic [NUM_W-1:0]             numu5_r, numv5_r;
  logic [DEN_W-1:0]             den5_r;
  logic [bary3d_pkg::TAG_W-1:0] tag5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      numu5_r <= (NUM_W'(anu) << (WEIGHT_FRAC_BITS + 1)) + NUM_W'(ad);
      numv5_r <= (NUM_W'(anv) << (WEIGHT_FRAC_BITS + 1)) + NUM_W'(ad);
      // zero divisor is replaced by one to keep the divider quiet
      den5_r  <= (d4_r == '0) ? DEN_W'(1) : {ad, 1'b0};
      tag5_r[bary3d_pkg::TAG_NEG_U] <= nu[MW-1] ^ d4_r[MW-1];
      tag5_r[bary3d_pkg::TAG_NEG_V] <= nv[MW-1] ^ d4_r[MW-1];
      tag5_r[bary3d_pkg::TAG_DEG]   <= (d4_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // divider
  logic                         dv_valid;
  logic [NUM_W-1:0]             quo_u, quo_v;
  logic [bary3d_pkg::TAG_W-1:0] dv_tag;

  bary3d_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v5_r),
    .in_num_u  (numu5_r),
    .in_num_v  (numv5_r),
    .in_den    (den5_r),
    .in_tag    (tag5_r),
    .out_valid (dv_valid),
    .out_quo_u (quo_u),
    .out_quo_v (quo_v),
    .out_tag   (dv_tag)
  );

  // sign, third weight and saturation
  logic signed [SW-1:0] su, sv, sw;
  logic signed [OW-1:0] wa_nxt, wb_nxt, wc_nxt;

  always_comb begin
    su = dv_tag[bary3d_pkg::TAG_NEG_U] ? -SW'(quo_u) : SW'(quo_u);
    sv = dv_tag[bary3d_pkg::TAG_NEG_V] ? -SW'(quo_v) : SW'(quo_v);
    sw = W_ONE - su - sv;
    wa_nxt = (su > W_MAX) ? OW'(W_MAX) : (su < W_MIN) ? OW'(W_MIN) : OW'(su);
    wb_nxt = (sv > W_MAX) ? OW'(W_MAX) : (sv < W_MIN) ? OW'(W_MIN) : OW'(sv);
    wc_nxt = (sw > W_MAX) ? OW'(W_MAX) : (sw < W_MIN) ? OW'(W_MIN) : OW'(sw);
    if (dv_tag[bary3d_pkg::TAG_DEG]) begin
      wa_nxt = '0;
      wb_nxt = '0;
      wc_nxt = '0;
    end
  end

  logic signed [OW-1:0] wa_r, wb_r, wc_r;
  logic                 deg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wa_r  <= wa_nxt;
      wb_r  <= wb_nxt;
      wc_r  <= wc_nxt;
      deg_r <= dv_tag[bary3d_pkg::TAG_DEG];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_weight_a   = wa_r;
  assign out_weight_b   = wb_r;
  assign out_weight_c   = wc_r;
  assign out_degenerate = deg_r;

  a_deg_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      out_weight_a == '0 && out_weight_b == '0 && out_weight_c == '0)
    else $error("degenerate result with non-zero weights");

  a_reset_empty : assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result present straight after reset");

  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

endmodule
